### src/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### src/spt_pkg.sv
// Package with widths, the number type, the sequencer state type and a packed divider control type.
package spt_pkg;
  localparam int unsigned NUMBER_WIDTH = 16;
  localparam int unsigned CAND_WIDTH = 16;
  localparam int unsigned IN_TDATA_WIDTH = 16;
  localparam int unsigned OUT_TDATA_WIDTH = 24;
  localparam int unsigned CNT_WIDTH = $clog2(NUMBER_WIDTH + 1);

  typedef logic [NUMBER_WIDTH-1:0] num_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_CHECK,
    ST_DONE
  } div_state_e;

  typedef struct packed {
    logic start;
  } div_ctrl_t;
endpackage

### src/spt_divider.sv
// Restoring bit-serial divider: one quotient bit per cycle.
module spt_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  spt_pkg::num_t       dividend_i,
  input  spt_pkg::num_t       divisor_i,
  output logic                done_o,
  output spt_pkg::num_t       quot_o,
  output spt_pkg::num_t       rem_o
);
  import spt_pkg::*;

  num_t quot_q, quot_d;
  num_t rem_q, rem_d;
  num_t dvs_q, dvs_d;
  logic [CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic run_q, run_d;
  logic done_q, done_d;
  logic [NUMBER_WIDTH:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    run_d = run_q;
    done_d = 1'b0;
    trial = {rem_q, quot_q[NUMBER_WIDTH-1]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = CNT_WIDTH'(NUMBER_WIDTH);
      run_d = 1'b1;
    end else if (run_q) begin
      // Shift in the next dividend bit, subtract when it fits.
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = NUMBER_WIDTH'(trial - {1'b0, dvs_q});
        quot_d = {quot_q[NUMBER_WIDTH-2:0], 1'b1};
      end else begin
        rem_d = trial[NUMBER_WIDTH-1:0];
        quot_d = {quot_q[NUMBER_WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_WIDTH'(1)) begin
        run_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o = rem_q;
endmodule

### src/spt_seq.sv
// Sequencer that runs trial division at most twice: least factor of n, then of n/p.
module spt_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          go_i,
  input  spt_pkg::num_t num_i,
  output logic          done_o,
  output logic          verdict_o
);
  import spt_pkg::*;

  div_state_e state_q, state_d;
  num_t n_q, n_d;
  num_t d_q, d_d;
  logic pass_q, pass_d;
  logic verdict_q, verdict_d;
  div_ctrl_t ctl;
  logic div_done;
  num_t quot, rem;
  logic [2*NUMBER_WIDTH-1:0] sq;
  logic [NUMBER_WIDTH:0] sq_hi;

  spt_divider u_div (
    .clk_i, .rst_ni,
    .start_i(ctl.start),
    .dividend_i(n_q),
    .divisor_i(d_q),
    .done_o(div_done),
    .quot_o(quot),
    .rem_o(rem)
  );

  // Square of the divisor for the loop bound.
  assign sq = {{NUMBER_WIDTH{1'b0}}, d_q} * {{NUMBER_WIDTH{1'b0}}, d_q};
  assign sq_hi = (NUMBER_WIDTH+1)'(sq >> NUMBER_WIDTH);

  always_comb begin
    state_d = state_q;
    n_d = n_q;
    d_d = d_q;
    pass_d = pass_q;
    verdict_d = verdict_q;
    unique case (state_q)
      ST_IDLE: begin
        if (go_i) begin
          n_d = num_i;
          d_d = NUMBER_WIDTH'(2);
          pass_d = 1'b0;
          verdict_d = 1'b0;
          state_d = (num_i < NUMBER_WIDTH'(4)) ? ST_DONE : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sq_hi != '0 || sq[NUMBER_WIDTH-1:0] > n_q) begin
          // No factor up to the square root: n is prime.
          verdict_d = pass_q;
          state_d = ST_DONE;
        end else begin
          state_d = ST_START;
        end
      end
      ST_START: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          if (rem == '0) begin
            if (pass_q) begin
              verdict_d = 1'b0;
              state_d = ST_DONE;
            end else if (quot < NUMBER_WIDTH'(2)) begin
              state_d = ST_DONE;
            end else begin
              pass_d = 1'b1;
              n_d = quot;
              d_d = NUMBER_WIDTH'(2);
              state_d = ST_CHECK;
            end
          end else begin
            d_d = d_q + 1'b1;
            state_d = ST_CHECK;
          end
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.start = (state_q == ST_START);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q <= 1'b0;
      verdict_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q <= pass_d;
      verdict_q <= verdict_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    d_q <= d_d;
  end

  assign done_o = (state_q == ST_DONE);
  assign verdict_o = verdict_q;
endmodule

### src/semiprime_test_stream.sv
// Top level of the streaming semiprime tester.
//
//  channel | dir | beat content
//  s_axis  | in  | tdata: candidate[15:0]; tlast: last_in_range
//  m_axis  | out | tdata: tested_number[15:0], is_semiprime, any_found,
//          |     |        zero pad; tlast: range_done
//
// Each beat is tested by trial division: for each trial divisor up to the
// square root, the sequencer checks the bound, starts the bit-serial divider
// and waits for its quotient and remainder.
// One beat is in work at a time; the result waits in an output register, and
// the next beat is taken once the tester is free and that register is empty
// or draining, so a stalled receiver holds off the input. Reset clears the
// range mark and all control state.
module semiprime_test_stream (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // candidate[15:0]
  input  logic [spt_pkg::IN_TDATA_WIDTH-1:0]  s_axis_tdata,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tested_number[15:0], is_semiprime[16], any_found[17]
  output logic [spt_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,
  output logic                                m_axis_tlast
);
  import spt_pkg::*;

  logic busy_q, busy_d;
  logic last_q;
  num_t num_q;
  logic found_q, found_d;
  logic ovalid_q, ovalid_d;
  logic [OUT_TDATA_WIDTH-1:0] odata_q, odata_d;
  logic olast_q, olast_d;
  logic seq_done, verdict, in_fire, all_found;

  // Take a beat only when the tester is free and the output slot is empty
  // or being drained.
  assign s_axis_tready = !busy_q && (!ovalid_q || m_axis_tready);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  spt_seq u_seq (
    .clk_i, .rst_ni,
    .go_i(in_fire),
    .num_i(s_axis_tdata[NUMBER_WIDTH-1:0]),
    .done_o(seq_done),
    .verdict_o(verdict)
  );

  assign all_found = found_q | verdict;

  always_comb begin
    busy_d = busy_q;
    found_d = found_q;
    ovalid_d = ovalid_q;
    odata_d = odata_q;
    olast_d = olast_q;
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    if (in_fire) busy_d = 1'b1;
    if (seq_done) begin
      busy_d = 1'b0;
      ovalid_d = 1'b1;
      odata_d = {6'b0, last_q & all_found, verdict, CAND_WIDTH'(num_q)};
      olast_d = last_q;
      found_d = last_q ? 1'b0 : all_found;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      found_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      found_q <= found_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
    olast_q <= olast_d;
    if (in_fire) begin
      num_q <= s_axis_tdata[NUMBER_WIDTH-1:0];
      last_q <= s_axis_tlast;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = odata_q;
  assign m_axis_tlast = olast_q;
endmodule

### src/spt_checker.sv
// Port-level checker for the semiprime tester, bound to the top level.
`include "assert_macros.svh"
module spt_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [spt_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,
  input logic                                m_axis_tlast
);
  `ASSERT_IMPL(a_any_only_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[17],
    m_axis_tlast, "any_found without range_done")
  `ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
    !s_axis_tready, "second beat taken while testing")
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
    "result dropped while stalled")
endmodule

bind semiprime_test_stream spt_checker u_spt_checker (.*);
